### rtl/core/pvs_pkg.sv
// Shared constants, types and state encoding for the palette voxel store.
// Used by pvs_slot_ram and palette_refcount_voxel_store_core.
package pvs_pkg;

  localparam int unsigned CHUNK_VOXELS    = 4096;
  localparam int unsigned PALETTE_ENTRIES = 16;
  localparam int unsigned VOXEL_AW        = $clog2(CHUNK_VOXELS);
  localparam int unsigned SLOT_W          = $clog2(PALETTE_ENTRIES);
  localparam int unsigned COUNT_W         = $clog2(CHUNK_VOXELS) + 1;
  localparam int unsigned TYPE_W          = 32;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MATCH,
    ST_OLDCHK,
    ST_FREE,
    ST_FULL,
    ST_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    CNT_ADJ,
    CNT_ONE,
    CNT_SAVED
  } cnt_src_e;

  // Write port of the voxel slot memory.
  typedef struct packed {
    logic                en;
    logic [VOXEL_AW-1:0] addr;
    logic [SLOT_W-1:0]   data;
  } slot_wr_t;

  // Control word produced by the sequencer for the datapath.
  typedef struct packed {
    logic     ptr_rdata;
    logic     ptr_old;
    logic     type_we;
    logic     cnt_we;
    cnt_src_e cnt_src;
    logic     cnt_inc;
    logic     idx_clr;
    logic     idx_inc;
    logic     old_ld;
    logic     new_ld;
    logic     out_ld;
    logic     out_full;
    logic     out_from_entry;
  } ctl_t;

endpackage

### rtl/core/palette_refcount_voxel_store_core.sv
// Palette voxel store. After reset all 4096 slot memory entries are swept to zero,
// during which no transaction is accepted. A read result is loaded from the lookup
// state. A write takes one slot lookup and a match scan of up to 16 entries; without a
// match, one check of the old entry, a free scan of up to 16 entries if that is in use,
// and one commit or refusal step, all through one compare and count adjust unit. The
// next transaction is taken in the cycle after the result is accepted at the output.
module palette_refcount_voxel_store_core
  import pvs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [11:0]         voxel_index_i,
  input  logic [TYPE_W-1:0]   voxel_type_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TYPE_W-1:0]   read_type_o,
  output logic                status_o
);

  state_e state_q, state_d;
  ctl_t   ctl;

  logic [TYPE_W-1:0]   types_q  [PALETTE_ENTRIES];
  logic [COUNT_W-1:0]  counts_q [PALETTE_ENTRIES];

  logic                cmd_q;
  logic [VOXEL_AW-1:0] vidx_q;
  logic [TYPE_W-1:0]   vtype_q;
  logic [SLOT_W-1:0]   idx_q, old_q, new_q;
  logic [COUNT_W-1:0]  saved_q;
  logic [VOXEL_AW-1:0] clr_q;
  logic                out_valid_q, status_q;
  logic [TYPE_W-1:0]   read_type_q;

  logic                in_accept, out_accept;
  logic [SLOT_W-1:0]   rdata;
  logic [SLOT_W-1:0]   ptr;
  logic [TYPE_W-1:0]   type_rd;
  logic [COUNT_W-1:0]  cnt_rd, cnt_adj, cnt_wdata;
  logic                type_hit, cnt_zero, idx_last, clr_last;
  slot_wr_t            slot_wr;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && !out_valid_q);

  assign idx_last = (idx_q == SLOT_W'(PALETTE_ENTRIES - 1));
  assign clr_last = (clr_q == VOXEL_AW'(CHUNK_VOXELS - 1));

  // The one shared unit: a single palette read, a type compare and a count adjust.
  always_comb begin
    priority if (ctl.ptr_rdata) begin
      ptr = rdata;
    end else if (ctl.ptr_old) begin
      ptr = old_q;
    end else begin
      ptr = idx_q;
    end
  end

  assign type_rd  = types_q[ptr];
  assign cnt_rd   = counts_q[ptr];
  assign type_hit = (type_rd == vtype_q);
  assign cnt_zero = (cnt_rd == '0);

  // Release saturates at zero; acquire adds one.
  always_comb begin
    if (ctl.cnt_inc) begin
      cnt_adj = cnt_rd + COUNT_W'(1);
    end else if (cnt_zero) begin
      cnt_adj = '0;
    end else begin
      cnt_adj = cnt_rd - COUNT_W'(1);
    end
  end

  always_comb begin
    unique case (ctl.cnt_src)
      CNT_ADJ:   cnt_wdata = cnt_adj;
      CNT_ONE:   cnt_wdata = COUNT_W'(1);
      CNT_SAVED: cnt_wdata = saved_q;
      default:   cnt_wdata = cnt_adj;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_accept) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = (cmd_q == CMD_READ) ? ST_IDLE : ST_MATCH;
      ST_MATCH: begin
        if (type_hit) begin
          state_d = ST_COMMIT;
        end else if (idx_last) begin
          state_d = ST_OLDCHK;
        end
      end
      ST_OLDCHK: state_d = cnt_zero ? ST_COMMIT : ST_FREE;
      ST_FREE: begin
        if (cnt_zero) begin
          state_d = ST_COMMIT;
        end else if (idx_last) begin
          state_d = ST_FULL;
        end
      end
      ST_FULL:   state_d = ST_IDLE;
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl = '0;
    ctl.cnt_src = CNT_ADJ;
    unique case (state_q)
      ST_CLEAR, ST_IDLE, ST_COMMIT: begin
        ctl.out_ld = (state_q == ST_COMMIT);
      end
      ST_LOOKUP: begin
        ctl.ptr_rdata = 1'b1;
        if (cmd_q == CMD_READ) begin
          ctl.out_ld         = 1'b1;
          ctl.out_from_entry = 1'b1;
        end else begin
          ctl.cnt_we  = 1'b1;
          ctl.old_ld  = 1'b1;
          ctl.idx_clr = 1'b1;
        end
      end
      ST_MATCH: begin
        ctl.idx_inc = !type_hit;
        ctl.idx_clr = !type_hit && idx_last;
        if (type_hit) begin
          ctl.cnt_we  = 1'b1;
          ctl.cnt_inc = 1'b1;
          ctl.new_ld  = 1'b1;
        end
      end
      ST_OLDCHK: begin
        ctl.ptr_old = 1'b1;
        if (cnt_zero) begin
          ctl.type_we = 1'b1;
          ctl.cnt_we  = 1'b1;
          ctl.cnt_src = CNT_ONE;
          ctl.new_ld  = 1'b1;
        end
      end
      ST_FREE: begin
        ctl.idx_inc = !cnt_zero;
        if (cnt_zero) begin
          ctl.type_we = 1'b1;
          ctl.cnt_we  = 1'b1;
          ctl.cnt_src = CNT_ONE;
          ctl.new_ld  = 1'b1;
        end
      end
      ST_FULL: begin
        ctl.ptr_old        = 1'b1;
        ctl.cnt_we         = 1'b1;
        ctl.cnt_src        = CNT_SAVED;
        ctl.out_ld         = 1'b1;
        ctl.out_full       = 1'b1;
        ctl.out_from_entry = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + VOXEL_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < PALETTE_ENTRIES; e++) begin
        types_q[e]  <= '0;
        counts_q[e] <= (e == 0) ? COUNT_W'(CHUNK_VOXELS) : '0;
      end
    end else begin
      if (ctl.type_we) begin
        types_q[ptr] <= vtype_q;
      end
      if (ctl.cnt_we) begin
        counts_q[ptr] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_i;
      vidx_q  <= voxel_index_i[VOXEL_AW-1:0];
      vtype_q <= voxel_type_i;
    end
    if (ctl.old_ld) begin
      old_q   <= rdata;
      saved_q <= cnt_rd;
    end
    if (ctl.new_ld) begin
      new_q <= ptr;
    end
    if (ctl.idx_clr) begin
      idx_q <= '0;
    end else if (ctl.idx_inc) begin
      idx_q <= idx_q + SLOT_W'(1);
    end
    if (ctl.out_ld) begin
      read_type_q <= ctl.out_from_entry ? type_rd : vtype_q;
      status_q    <= ctl.out_full ? STATUS_FULL : STATUS_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  // The sweep after reset and the commit of a write share the single write port.
  always_comb begin
    slot_wr.en   = (state_q == ST_CLEAR) || (state_q == ST_COMMIT);
    slot_wr.addr = (state_q == ST_CLEAR) ? clr_q : vidx_q;
    slot_wr.data = (state_q == ST_CLEAR) ? '0 : new_q;
  end

  pvs_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .wr_i    (slot_wr),
    .re_i    (in_accept),
    .raddr_i (voxel_index_i[VOXEL_AW-1:0]),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign read_type_o = read_type_q;
  assign status_o    = status_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o && !out_valid_o)
    else $error("input taken while a transaction is in progress");

  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT |=> out_valid_o && status_o == STATUS_DONE)
    else $error("committed write did not report done");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FULL |=> out_valid_o && status_o == STATUS_FULL
                           && counts_q[old_q] == $past(saved_q))
    else $error("refused write did not restore the old count");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o && !out_valid_o)
    else $error("transaction possible during the slot sweep");

endmodule

### rtl/core/pvs_slot_ram.sv
// Voxel slot memory: one palette index per voxel, one write and one read port.
// Depends on pvs_pkg for widths and the write port type.
module pvs_slot_ram
  import pvs_pkg::*;
(
  input  logic                clk_i,
  input  slot_wr_t            wr_i,
  input  logic                re_i,
  input  logic [VOXEL_AW-1:0] raddr_i,
  output logic [SLOT_W-1:0]   rdata_o
);

  logic [SLOT_W-1:0] mem [CHUNK_VOXELS];
  logic [SLOT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
